// ===== hw/rtl/trs_pkg.sv =====
`timescale 1ns / 1ps

package trs_pkg;

	// Default widths of the sizable datapath pieces
	localparam int COUNTER_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF   = 9;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd4;

	// Register reset values
	localparam logic [4:0] MARGIN_RST = 5'd5;
	localparam logic [7:0] SETTLE_RST = 8'd5;

	// Word function codes
	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_MANUAL = 1'b1;

	typedef enum logic [2:0] {
		PH_SETTLE = 3'd0,
		PH_WAIT   = 3'd1,
		PH_REACH  = 3'd2,
		PH_HOLD   = 3'd3,
		PH_RETURN = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		PAT_OFF         = 3'd0,
		PAT_RED         = 3'd1,
		PAT_BLINK_GREEN = 3'd2,
		PAT_GREEN       = 3'd3,
		PAT_BLINK_LEDS  = 3'd4,
		PAT_MANUAL_ON   = 3'd5
	} pattern_t;

	typedef struct packed {
		logic [15:0] reminder_period_s;
		logic [15:0] hold_duration_s;
		logic [7:0]  target_angle;
		logic [4:0]  angle_margin;
		logic [7:0]  settle_seconds;
	} cfg_t;

	// Sequencer control state, counter travels beside it
	typedef struct packed {
		phase_t   phase;
		pattern_t pattern;
		logic     ovr_pend;
		logic     ovr_val;
	} ctl_t;

	// Single-bit fields of an input word
	typedef struct packed {
		logic func;
		logic present;
		logic moving;
		logic inclined;
		logic manual_on;
	} flags_t;

endpackage

// ===== hw/rtl/trs_in_if.sv =====
`timescale 1ns / 1ps

interface trs_in_if #(
	parameter int ANGLE_BITS = 9
);
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic                         occupant_present;
	logic                         chair_moving;
	logic                         chair_inclined;
	logic signed [ANGLE_BITS-1:0] seat_angle;
	logic                         manual_alarm_on;

	modport source (
		output valid, func, occupant_present, chair_moving, chair_inclined,
		       seat_angle, manual_alarm_on,
		input  ready
	);

	modport sink (
		input  valid, func, occupant_present, chair_moving, chair_inclined,
		       seat_angle, manual_alarm_on,
		output ready
	);
endinterface

// ===== hw/rtl/trs_out_if.sv =====
`timescale 1ns / 1ps

interface trs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  phase;
	logic [15:0] seconds_count;
	logic [2:0]  alarm_pattern;

	modport source (
		output valid, phase, seconds_count, alarm_pattern,
		input  ready
	);

	modport sink (
		input  valid, phase, seconds_count, alarm_pattern,
		output ready
	);
endinterface

// ===== hw/rtl/trs_cfg_regs.sv =====
`timescale 1ns / 1ps

module trs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [trs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [trs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output trs_pkg::cfg_t                  cfg,
	output logic                           restart
);
	import trs_pkg::*;

	cfg_t cfg_q;

	// Store the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reminder_period_s <= '0;
			cfg_q.hold_duration_s   <= '0;
			cfg_q.target_angle      <= '0;
			cfg_q.angle_margin      <= MARGIN_RST;
			cfg_q.settle_seconds    <= SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PERIOD:   cfg_q.reminder_period_s <= cfg_wdata;
				REG_DURATION: cfg_q.hold_duration_s   <= cfg_wdata;
				REG_ANGLE:    cfg_q.target_angle      <= cfg_wdata[7:0];
				REG_MARGIN:   cfg_q.angle_margin      <= cfg_wdata[4:0];
				REG_SETTLE:   cfg_q.settle_seconds    <= cfg_wdata[7:0];
				default:      ;
			endcase
		end
	end

	// Period, duration and angle writes restart the sequence
	assign restart = cfg_we && (cfg_idx == REG_PERIOD || cfg_idx == REG_DURATION ||
	                            cfg_idx == REG_ANGLE);
	assign cfg     = cfg_q;
endmodule

// ===== hw/rtl/trs_step_logic.sv =====
`timescale 1ns / 1ps

module trs_step_logic #(
	parameter int COUNTER_BITS = trs_pkg::COUNTER_BITS_DEF,
	parameter int ANGLE_BITS   = trs_pkg::ANGLE_BITS_DEF
) (
	input  trs_pkg::cfg_t                cfg,
	input  trs_pkg::ctl_t                ctl,
	input  logic [COUNTER_BITS-1:0]      cnt,
	input  trs_pkg::flags_t              flags,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output trs_pkg::ctl_t                ctl_nxt,
	output logic [COUNTER_BITS-1:0]      cnt_nxt
);
	import trs_pkg::*;

	// Wide enough for the sample and for target minus margin
	localparam int AW = ((ANGLE_BITS > 10) ? ANGLE_BITS : 10) + 1;
	localparam int CW = 32;

	logic signed [AW-1:0]    ang_x;
	logic signed [AW-1:0]    thr_x;
	logic                    above;
	logic                    below;
	logic [COUNTER_BITS-1:0] cnt_inc;
	logic [CW-1:0]           inc_x;
	logic                    any_zero;

	assign ang_x = AW'(angle);
	assign thr_x = $signed(AW'(cfg.target_angle)) - $signed(AW'(cfg.angle_margin));
	assign above = ang_x > thr_x;
	assign below = ang_x < thr_x;

	// Saturating increment
	assign cnt_inc = (cnt == {COUNTER_BITS{1'b1}}) ? cnt : cnt + 1'b1;
	assign inc_x   = CW'(cnt_inc);

	assign any_zero = (cfg.hold_duration_s == '0) || (cfg.reminder_period_s == '0) ||
	                  (cfg.target_angle == '0);

	// One step of the reminder sequence
	always_comb begin
		ctl_nxt = ctl;
		cnt_nxt = cnt;
		if (flags.func == FUNC_MANUAL) begin
			ctl_nxt.ovr_pend = 1'b1;
			ctl_nxt.ovr_val  = flags.manual_on;
		end else if (ctl.ovr_pend) begin
			ctl_nxt.pattern  = ctl.ovr_val ? PAT_MANUAL_ON : PAT_OFF;
			ctl_nxt.ovr_pend = 1'b0;
		end else if (!flags.present || any_zero) begin
			ctl_nxt.phase   = PH_SETTLE;
			ctl_nxt.pattern = PAT_OFF;
			cnt_nxt         = '0;
		end else begin
			unique case (ctl.phase)
				PH_SETTLE: begin
					cnt_nxt = cnt_inc;
					if (inc_x >= CW'(cfg.settle_seconds)) begin
						ctl_nxt.phase = PH_WAIT;
						cnt_nxt       = '0;
					end
				end
				PH_WAIT: begin
					cnt_nxt = cnt_inc;
					if (inc_x >= CW'(cfg.reminder_period_s)) begin
						if (!flags.moving && !flags.inclined) begin
							ctl_nxt.pattern = PAT_RED;
							ctl_nxt.phase   = PH_REACH;
							cnt_nxt         = '0;
						end else begin
							ctl_nxt.pattern = PAT_BLINK_GREEN;
						end
					end
				end
				PH_REACH: begin
					if (above) begin
						ctl_nxt.pattern = PAT_GREEN;
						ctl_nxt.phase   = PH_HOLD;
					end
				end
				PH_HOLD: begin
					if (above) begin
						cnt_nxt = cnt_inc;
						if (inc_x >= CW'(cfg.hold_duration_s)) begin
							if (ctl.pattern != PAT_BLINK_GREEN)
								ctl_nxt.pattern = PAT_BLINK_LEDS;
							ctl_nxt.phase = PH_RETURN;
						end
					end else begin
						ctl_nxt.pattern = PAT_RED;
						ctl_nxt.phase   = PH_REACH;
						cnt_nxt         = '0;
					end
				end
				PH_RETURN: begin
					cnt_nxt = cnt_inc;
					if (below) begin
						ctl_nxt.phase = PH_WAIT;
						cnt_nxt       = '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/tilt_reminder_sequencer.sv =====
`timescale 1ns / 1ps

// Tilt reminder sequencer.
// item_in carries one word per call: a one-second tick with occupancy, motion,
// slope and seat-angle samples (func 0), or a manual alarm command (func 1).
// result_out returns exactly one word per input word: phase, the phase seconds
// counter (low 16 bits) and the alarm pattern, as they stand after that word.
// The cfg port writes a register at any edge with cfg_we high; writing the
// period, hold duration or target angle restarts the sequence at settle.
// Write configuration only while no word is in flight.
// A word accepted into the input register is stepped there and loaded into
// the result register, where it stays visible until the receiver takes it.
// Throughput: one word per cycle unless the receiver stalls; the step is a
// single pass of compare and count logic between the input and result registers.
// Reset clears the sequence to settle with the alarm off, loads the register
// defaults and empties both registers. When the receiver stalls, the result
// holds and item_in.ready drops once the input register is full.
module tilt_reminder_sequencer #(
	parameter int COUNTER_BITS = trs_pkg::COUNTER_BITS_DEF,
	parameter int ANGLE_BITS   = trs_pkg::ANGLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [trs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [trs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	trs_in_if.sink                         item_in,
	trs_out_if.source                      result_out
);
	import trs_pkg::*;

	cfg_t                    cfg;
	logic                    restart;

	// Input register
	logic                    v_s1;
	flags_t                  flags_s1;
	logic signed [ANGLE_BITS-1:0] angle_s1;

	// Sequencer state
	ctl_t                    ctl_q;
	logic [COUNTER_BITS-1:0] cnt_q;
	ctl_t                    ctl_nxt;
	logic [COUNTER_BITS-1:0] cnt_nxt;

	// Result register
	logic                    out_v_q;
	logic [2:0]              out_phase_q;
	logic [15:0]             out_cnt_q;
	logic [2:0]              out_pat_q;

	logic                    adv_s1;
	logic                    take_in;
	logic [COUNTER_BITS+15:0] cnt_ext;

	trs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.restart   (restart)
	);

	trs_step_logic #(
		.COUNTER_BITS (COUNTER_BITS),
		.ANGLE_BITS   (ANGLE_BITS)
	) u_step (
		.cfg     (cfg),
		.ctl     (ctl_q),
		.cnt     (cnt_q),
		.flags   (flags_s1),
		.angle   (angle_s1),
		.ctl_nxt (ctl_nxt),
		.cnt_nxt (cnt_nxt)
	);

	// Step the word when the result register is free or being drained
	assign adv_s1        = v_s1 && (!out_v_q || result_out.ready);
	assign item_in.ready = !v_s1 || adv_s1;
	assign take_in       = item_in.valid && item_in.ready;

	// Hold or load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_in.ready) begin
			v_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			flags_s1.func      <= item_in.func;
			flags_s1.present   <= item_in.occupant_present;
			flags_s1.moving    <= item_in.chair_moving;
			flags_s1.inclined  <= item_in.chair_inclined;
			flags_s1.manual_on <= item_in.manual_alarm_on;
			angle_s1           <= item_in.seat_angle;
		end
	end

	// Advance the sequencer state; period, duration and angle writes restart it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase    <= PH_SETTLE;
			ctl_q.pattern  <= PAT_OFF;
			ctl_q.ovr_pend <= 1'b0;
			ctl_q.ovr_val  <= 1'b0;
			cnt_q          <= '0;
		end else if (restart) begin
			ctl_q.phase <= PH_SETTLE;
			cnt_q       <= '0;
		end else if (adv_s1) begin
			ctl_q <= ctl_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	assign cnt_ext = {16'd0, cnt_nxt};

	// Load the result register, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_phase_q <= ctl_nxt.phase;
			out_cnt_q   <= cnt_ext[15:0];
			out_pat_q   <= ctl_nxt.pattern;
		end
	end

	assign result_out.valid         = out_v_q;
	assign result_out.phase         = out_phase_q;
	assign result_out.seconds_count = out_cnt_q;
	assign result_out.alarm_pattern = out_pat_q;

	// Input stalls only behind a result the receiver refuses
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_in.ready |-> (result_out.valid && !result_out.ready))
		else $error("input stalled without a blocked result");

	// A restarting write leaves the sequence at settle with a clear counter
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (ctl_q.phase == PH_SETTLE && cnt_q == '0))
		else $error("configuration write did not restart sequence");

	// A pending override only comes from a stepped manual command
	a_ovr_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctl_q.ovr_pend) |-> $past(adv_s1 && flags_s1.func == FUNC_MANUAL))
		else $error("override raised without manual command");

	// The result shows the state it left behind
	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !restart) |=> (result_out.phase == ctl_q.phase &&
		                          result_out.alarm_pattern == ctl_q.pattern))
		else $error("result does not match sequencer state");
endmodule

// ===== tb/sv/tilt_reminder_sequencer_tb.sv =====
`timescale 1ns / 1ps

module tilt_reminder_sequencer_tb;
	import trs_pkg::*;

	localparam int ANGLE_W     = ANGLE_BITS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic               func;
		logic               present;
		logic               moving;
		logic               inclined;
		logic [ANGLE_W-1:0] angle;
		logic               manual_on;
	} chair_word_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] seconds;
		pattern_t    pattern;
	} chair_status_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	trs_in_if #(.ANGLE_BITS(ANGLE_W)) item_if ();
	trs_out_if result_if ();

	tilt_reminder_sequencer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.item_in    (item_if),
		.result_out (result_if)
	);

	// Mirror of the settings and the sequencer state
	cfg_t        cfg_mirror;
	phase_t      seq_phase;
	logic [15:0] seq_seconds;
	pattern_t    seq_pattern;
	logic        pend_valid;
	logic        pend_on;

	chair_status_t status_q[$];
	chair_status_t expected_status;
	int            mismatch_count;
	int            cycle_count;
	bit            pace_on;
	int            burst_left;
	int            stall_pct;
	int            run_left;
	bit            stalled;

	// Clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void seq_restart();
		seq_phase   = PH_SETTLE;
		seq_seconds = '0;
	endfunction

	function automatic void seq_count();
		if (seq_seconds != COUNT_TOP) begin
			seq_seconds++;
		end
	endfunction

	// Step the mirrored sequencer with one word and return the status after it
	function automatic chair_status_t step_chair(chair_word_t w);
		int            thr;
		int            ang;
		chair_status_t st;
		thr = int'(cfg_mirror.target_angle) - int'(cfg_mirror.angle_margin);
		ang = $signed(w.angle);
		if (w.func == FUNC_MANUAL) begin
			pend_valid = 1'b1;
			pend_on    = w.manual_on;
		end else if (pend_valid) begin
			// a stored command takes the place of this step
			seq_pattern = pend_on ? PAT_MANUAL_ON : PAT_OFF;
			pend_valid  = 1'b0;
		end else if (!w.present || cfg_mirror.hold_duration_s == 0 ||
				cfg_mirror.reminder_period_s == 0 || cfg_mirror.target_angle == 0) begin
			seq_restart();
			seq_pattern = PAT_OFF;
		end else begin
			case (seq_phase)
				PH_SETTLE: begin
					seq_count();
					if (seq_seconds >= {8'd0, cfg_mirror.settle_seconds}) begin
						seq_phase   = PH_WAIT;
						seq_seconds = '0;
					end
				end
				PH_WAIT: begin
					seq_count();
					if (seq_seconds >= cfg_mirror.reminder_period_s) begin
						if (!w.moving && !w.inclined) begin
							seq_pattern = PAT_RED;
							seq_phase   = PH_REACH;
							seq_seconds = '0;
						end else begin
							seq_pattern = PAT_BLINK_GREEN;
						end
					end
				end
				PH_REACH: begin
					if (ang > thr) begin
						seq_pattern = PAT_GREEN;
						seq_phase   = PH_HOLD;
					end
				end
				PH_HOLD: begin
					if (ang > thr) begin
						seq_count();
						if (seq_seconds >= cfg_mirror.hold_duration_s) begin
							if (seq_pattern != PAT_BLINK_GREEN) begin
								seq_pattern = PAT_BLINK_LEDS;
							end
							seq_phase = PH_RETURN;
						end
					end else begin
						seq_pattern = PAT_RED;
						seq_phase   = PH_REACH;
						seq_seconds = '0;
					end
				end
				PH_RETURN: begin
					seq_count();
					if (ang < thr) begin
						seq_phase   = PH_WAIT;
						seq_seconds = '0;
					end
				end
				default: begin
				end
			endcase
		end
		st.phase   = seq_phase;
		st.seconds = seq_seconds;
		st.pattern = seq_pattern;
		return st;
	endfunction

	// Offer one word, wait for the handshake, then idle at a burst's end when pacing
	task automatic send_word(chair_word_t w);
		item_if.valid            <= 1'b1;
		item_if.func             <= w.func;
		item_if.occupant_present <= w.present;
		item_if.chair_moving     <= w.moving;
		item_if.chair_inclined   <= w.inclined;
		item_if.seat_angle       <= w.angle;
		item_if.manual_alarm_on  <= w.manual_on;
		do @(posedge clk); while (!item_if.ready);
		status_q.push_back(step_chair(w));
		if (pace_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				item_if.valid <= 1'b0;
				repeat ($urandom_range(5, 1)) @(posedge clk);
				burst_left = $urandom_range(12, 1);
			end
		end
	endtask

	task automatic send_tick(bit present, bit moving, bit inclined, int angle);
		chair_word_t w;
		w.func      = FUNC_TICK;
		w.present   = present;
		w.moving    = moving;
		w.inclined  = inclined;
		w.angle     = angle[ANGLE_W-1:0];
		w.manual_on = 1'($urandom_range(1, 0));
		send_word(w);
	endtask

	// Command word; the sample fields ride along as noise
	task automatic send_manual(bit on);
		chair_word_t w;
		w.func      = FUNC_MANUAL;
		w.present   = 1'($urandom_range(1, 0));
		w.moving    = 1'($urandom_range(1, 0));
		w.inclined  = 1'($urandom_range(1, 0));
		w.angle     = ANGLE_W'($urandom_range(511, 0));
		w.manual_on = on;
		send_word(w);
	endtask

	// Drop valid and wait until every predicted word is back
	task automatic drain();
		item_if.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_PERIOD: begin
				cfg_mirror.reminder_period_s = data;
				seq_restart();
			end
			REG_DURATION: begin
				cfg_mirror.hold_duration_s = data;
				seq_restart();
			end
			REG_ANGLE: begin
				cfg_mirror.target_angle = data[7:0];
				seq_restart();
			end
			REG_MARGIN: cfg_mirror.angle_margin = data[4:0];
			REG_SETTLE: cfg_mirror.settle_seconds = data[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic cfg_close();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_all(int period, int hold, int target, int margin, int settle);
		drain();
		cfg_write(REG_PERIOD, CFG_DATA_W'(period));
		cfg_write(REG_DURATION, CFG_DATA_W'(hold));
		cfg_write(REG_ANGLE, CFG_DATA_W'(target));
		cfg_write(REG_MARGIN, CFG_DATA_W'(margin));
		cfg_write(REG_SETTLE, CFG_DATA_W'(settle));
		cfg_close();
	endtask

	// Reset state: sequence disabled, manual commands, default margin and settle
	task automatic test_reset_state();
		send_tick(1, 0, 0, 100);
		send_tick(1, 1, 1, -100);
		send_manual(1);
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 0);
		send_manual(0);
		send_manual(1);
		send_tick(0, 0, 0, 0);
		drain();
		cfg_write(REG_PERIOD, 16'd1);
		cfg_write(REG_DURATION, 16'd1);
		cfg_write(REG_ANGLE, 16'd20);
		cfg_close();
		repeat (6) send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 16);
		send_tick(1, 0, 0, 15);
	endtask

	// Walk every phase, every pattern and the angle extremes
	task automatic test_sequence();
		program_all(2, 2, 30, 5, 0);
		send_tick(1, 0, 0, 0);
		send_tick(1, 1, 0, 0);
		send_tick(1, 1, 0, 0);
		send_tick(1, 0, 1, 0);
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 25);
		send_tick(1, 0, 0, 26);
		send_tick(1, 0, 0, 255);
		send_tick(1, 0, 0, 25);
		send_tick(1, 0, 0, 255);
		send_manual(1);
		send_tick(1, 0, 0, 255);
		send_tick(1, 0, 0, 255);
		send_tick(1, 0, 0, 255);
		send_tick(1, 0, 0, 25);
		send_tick(1, 0, 0, -256);
		send_manual(0);
		send_manual(1);
		send_tick(0, 0, 0, 0);
		send_tick(0, 1, 1, -1);
	endtask

	// Register writes: restart on period, duration and angle, extremes, unused index
	task automatic test_settings();
		program_all(1, 1, 10, 31, 255);
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 0);
		drain();
		cfg_write(REG_MARGIN, 16'd0);
		cfg_write(REG_UNUSED, 16'hFFFF);
		cfg_close();
		send_tick(1, 0, 0, 0);
		drain();
		cfg_write(REG_SETTLE, 16'd1);
		cfg_close();
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 10);
		send_tick(1, 0, 0, 11);
		drain();
		cfg_write(REG_PERIOD, 16'hFFFF);
		cfg_close();
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 0);
		send_tick(1, 1, 1, 0);
		program_all(1, 16'hFFFF, 255, 31, 1);
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 224);
		send_tick(1, 0, 0, 225);
		drain();
		cfg_write(REG_DURATION, 16'd0);
		cfg_close();
		send_tick(1, 0, 0, 0);
		program_all(0, 1, 50, 5, 1);
		send_tick(1, 0, 0, 0);
		program_all(1, 1, 0, 5, 1);
		send_tick(1, 0, 0, 0);
	endtask

	// Hold under the longest duration back to back, then drop below the threshold
	task automatic test_counter_top();
		program_all(1, 16'hFFFF, 180, 0, 1);
		pace_on   = 1'b0;
		stall_pct = 0;
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 0);
		send_tick(1, 0, 0, 181);
		repeat (10) send_tick(1, 0, 0, 200);
		repeat (4) send_tick(1, 0, 0, 181);
		send_tick(1, 0, 0, 179);
	endtask

	// Mostly well-formed seated sequences around the threshold, plus noise
	task automatic test_random();
		int thr;
		int angle;
		int pick;
		for (int round = 0; round < 8; round++) begin
			program_all($urandom_range(5, 1), $urandom_range(5, 1),
				(round == 7) ? 255 : $urandom_range(180, 1),
				$urandom_range(31, 0), $urandom_range(4, 0));
			pace_on   = (round != 3);
			stall_pct = (round == 3) ? 0 : ((round == 6) ? 80 : $urandom_range(50, 10));
			thr = int'(cfg_mirror.target_angle) - int'(cfg_mirror.angle_margin);
			repeat (72) begin
				pick = $urandom_range(99, 0);
				if (pick < 7) begin
					send_manual(1'($urandom_range(1, 0)));
				end else if (pick < 12) begin
					send_tick(0, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
						int'($urandom_range(511, 0)) - 256);
				end else begin
					if (pick < 20) begin
						angle = int'($urandom_range(511, 0)) - 256;
					end else begin
						angle = thr + int'($urandom_range(5, 0)) - 2;
					end
					if (angle > 255) begin
						angle = 255;
					end
					if (angle < -256) begin
						angle = -256;
					end
					send_tick(1, $urandom_range(99, 0) < 15, $urandom_range(99, 0) < 15, angle);
				end
			end
		end
	endtask

	// Receiver: runs of ready and stall of random length
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (run_left == 0) begin
				stalled  = ($urandom_range(99, 0) < stall_pct);
				run_left = $urandom_range(6, 1);
			end
			run_left--;
			result_if.ready <= !stalled;
		end
	end

	// Compare each returned word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (status_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("ERROR: unpredicted word phase %0d seconds %0d pattern %0d",
						result_if.phase, result_if.seconds_count, result_if.alarm_pattern);
				end
			end else begin
				expected_status = status_q.pop_front();
				if (result_if.phase !== expected_status.phase ||
						result_if.seconds_count !== expected_status.seconds ||
						result_if.alarm_pattern !== expected_status.pattern) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("ERROR: expected phase %0d seconds %0d pattern %0d,",
							expected_status.phase, expected_status.seconds,
							expected_status.pattern,
							" got phase %0d seconds %0d pattern %0d",
							result_if.phase, result_if.seconds_count,
							result_if.alarm_pattern);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n                   <= 1'b0;
		cfg_we                   <= 1'b0;
		cfg_idx                  <= '0;
		cfg_wdata                <= '0;
		item_if.valid            <= 1'b0;
		item_if.func             <= FUNC_TICK;
		item_if.occupant_present <= 1'b0;
		item_if.chair_moving     <= 1'b0;
		item_if.chair_inclined   <= 1'b0;
		item_if.seat_angle       <= '0;
		item_if.manual_alarm_on  <= 1'b0;
		cfg_mirror.reminder_period_s = '0;
		cfg_mirror.hold_duration_s   = '0;
		cfg_mirror.target_angle      = '0;
		cfg_mirror.angle_margin      = MARGIN_RST;
		cfg_mirror.settle_seconds    = SETTLE_RST;
		seq_restart();
		seq_pattern    = PAT_OFF;
		pend_valid     = 1'b0;
		pend_on        = 1'b0;
		mismatch_count = 0;
		pace_on        = 1'b1;
		burst_left     = 4;
		stall_pct      = 30;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_sequence();
		test_settings();
		test_counter_top();
		test_random();

		drain();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
